FILE: design/las_pkg.sv
// Package for the local alignment score block: payload structs, chain token
// and wavefront types, action and register codes. No dependencies.
package las_pkg;

   localparam int unsigned BASE_W  = 8;
   localparam int unsigned SCORE_W = 11;
   localparam int unsigned RSP_W   = 12;
   localparam int unsigned COEF_W  = 4;
   localparam int unsigned CALC_W  = 13;

   localparam logic [SCORE_W-1:0] SCORE_CAP  = 11'd2047;
   localparam logic [RSP_W-1:0]   SCORE_NONE = 12'hFFF;

   // action codes of an input beat
   localparam logic [1:0] ACT_APPEND = 2'd0;
   localparam logic [1:0] ACT_REF    = 2'd1;
   localparam logic [1:0] ACT_CLEAR  = 2'd2;

   // register indexes
   localparam logic [1:0] CSR_MATCH    = 2'd0;
   localparam logic [1:0] CSR_MISMATCH = 2'd1;
   localparam logic [1:0] CSR_GAP      = 2'd2;

   localparam logic [COEF_W-1:0] MATCH_RESET    = 4'd2;
   localparam logic [COEF_W-1:0] MISMATCH_RESET = 4'd1;
   localparam logic [COEF_W-1:0] GAP_RESET      = 4'd1;

   typedef struct packed {
      logic [1:0]        action;
      logic [BASE_W-1:0] base;
      logic              last;
   } req_type;

   typedef struct packed {
      logic signed [RSP_W-1:0] score;
      logic                    query_truncated;
   } rsp_type;

   typedef struct packed {
      logic [COEF_W-1:0] match_score;
      logic [COEF_W-1:0] mismatch_penalty;
      logic [COEF_W-1:0] gap_penalty;
   } cfg_type;

   // command token that walks down the chain, one cell per cycle while the chain advances
   typedef struct packed {
      logic              vld;
      logic [1:0]        kind;
      logic [BASE_W-1:0] base;
      logic              last;
      logic              trunc;
   } tok_type;

   // wavefront data riding with a reference token
   typedef struct packed {
      logic [SCORE_W-1:0] up;
      logic [SCORE_W-1:0] diag;
      logic               hit;
      logic [SCORE_W-1:0] colmax;
   } wave_type;

endpackage

FILE: design/las_cell.sv
// One systolic cell: holds one query base and its score column entry.
// Depends on las_pkg.
module las_cell #(
   parameter int unsigned IDX_W      = 7,
   parameter int unsigned CELL_INDEX = 0
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  las_pkg::cfg_type   cfg,
   input  las_pkg::tok_type   tok_i,
   input  logic [IDX_W-1:0]   idx_i,
   input  las_pkg::wave_type  wave_i,
   output las_pkg::tok_type   tok_o,
   output logic [IDX_W-1:0]   idx_o,
   output las_pkg::wave_type  wave_o
);

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_INDEX);

   las_pkg::tok_type                   tok_ff;
   logic [IDX_W-1:0]                   idx_ff;
   las_pkg::wave_type                  wave_ff, wave_in;
   logic [las_pkg::BASE_W-1:0]         base_ff, base_in;
   logic                               occ_ff, occ_in;
   logic [las_pkg::SCORE_W-1:0]        h_ff, h_in;
   logic [las_pkg::SCORE_W-1:0]        h_new;
   logic signed [las_pkg::CALC_W-1:0]  diag_s, up_s, left_s, gap_s, sub_s;
   logic signed [las_pkg::CALC_W-1:0]  cand, h_s;
   logic                               is_ref;

   always_comb begin
      diag_s = $signed({2'b00, wave_i.diag});
      up_s   = $signed({2'b00, wave_i.up});
      left_s = $signed({2'b00, h_ff});
      gap_s  = $signed({9'd0, cfg.gap_penalty});
      if (base_ff == tok_i.base) begin
         sub_s = $signed({9'd0, cfg.match_score});
      end else begin
         sub_s = -$signed({9'd0, cfg.mismatch_penalty});
      end
      h_s  = diag_s + sub_s;
      cand = up_s - gap_s;
      if (cand > h_s) begin
         h_s = cand;
      end
      cand = left_s - gap_s;
      if (cand > h_s) begin
         h_s = cand;
      end
      if (h_s < 0) begin
         h_new = '0;
      end else if (h_s > $signed({2'b00, las_pkg::SCORE_CAP})) begin
         h_new = las_pkg::SCORE_CAP;
      end else begin
         h_new = h_s[las_pkg::SCORE_W-1:0];
      end
   end

   assign is_ref = tok_i.vld && (tok_i.kind == las_pkg::ACT_REF) && occ_ff;

   always_comb begin
      base_in = base_ff;
      occ_in  = occ_ff;
      h_in    = h_ff;
      if (tok_i.vld) begin
         case (tok_i.kind)
            las_pkg::ACT_APPEND: begin
               if (idx_i == MY_IDX) begin
                  base_in = tok_i.base;
                  occ_in  = 1'b1;
                  h_in    = '0;
               end
            end
            las_pkg::ACT_REF: begin
               // zero the column once the window closes
               if (occ_ff) begin
                  h_in = tok_i.last ? '0 : h_new;
               end
            end
            las_pkg::ACT_CLEAR: begin
               occ_in = 1'b0;
               h_in   = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      wave_in = wave_i;
      if (is_ref) begin
         wave_in.up   = h_new;
         wave_in.diag = h_ff;
         wave_in.hit  = 1'b1;
         if (wave_i.hit && (wave_i.colmax > h_new)) begin
            wave_in.colmax = wave_i.colmax;
         end else begin
            wave_in.colmax = h_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= '0;
         occ_ff <= 1'b0;
         h_ff   <= '0;
      end else if (advance) begin
         tok_ff <= tok_i;
         occ_ff <= occ_in;
         h_ff   <= h_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         idx_ff  <= idx_i;
         wave_ff <= wave_in;
         base_ff <= base_in;
      end
   end

   assign tok_o  = tok_ff;
   assign idx_o  = idx_ff;
   assign wave_o = wave_ff;

endmodule

FILE: design/local_alignment_score.sv
// Top level of the local alignment score block: command head, cell chain,
// result fold and output register. Depends on las_pkg and las_cell.
//
// Usage:
//  - req_ channel carries one beat per action: append a query base, stream
//    a reference base (last marks the end of the window), or clear the query.
//  - rsp_ channel returns one beat per window, on the reference beat marked
//    last: the best local score (-1 for an empty query) and the truncation
//    flag. Query bases beyond MAX_QUERY are dropped and flagged.
//  - csr_ channel writes match, mismatch and gap coefficients; write only
//    while the block is idle. csr_ready is always high.
//  - Every beat, but a dropped query base, becomes a token that walks a
//    chain of MAX_QUERY cells, one cell per cycle while the chain advances;
//    cell i owns query position i and its score entry. A reference base
//    can enter every cycle, so sustained throughput is one beat per cycle
//    when the chain does not stall. An accepted beat lands in cell 0, walks
//    the chain, and its result is then registered in the output register.
//  - Reset (synchronous) restores the coefficients to 2/1/1, empties the
//    query and scores, and drops tokens in flight. No clearing pass.
//  - When a result waits in the output register and rsp_ready is low, the
//    chain keeps flowing until the next result token reaches the tail;
//    only then does the whole chain and req_ready stall.
module local_alignment_score #(
   parameter int unsigned MAX_QUERY = 128
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  las_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output las_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [las_pkg::COEF_W-1:0] csr_data
);

   localparam int unsigned IDX_W = (MAX_QUERY > 1) ? $clog2(MAX_QUERY) : 1;
   localparam int unsigned LEN_W = $clog2(MAX_QUERY + 1);
   localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(MAX_QUERY);

   las_pkg::cfg_type   cfg_ff, cfg_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic               trunc_ff, trunc_in;
   logic               best_hit_ff, best_hit_in;
   logic [las_pkg::SCORE_W-1:0] best_ff, best_in;
   logic               rsp_valid_ff, rsp_valid_in;
   las_pkg::rsp_type   rsp_data_ff, rsp_data_in;

   las_pkg::tok_type   tok_chain  [MAX_QUERY+1];
   logic [IDX_W-1:0]   idx_chain  [MAX_QUERY+1];
   las_pkg::wave_type  wave_chain [MAX_QUERY+1];

   logic               advance;
   logic               req_fire;
   logic               tail_result;
   las_pkg::tok_type   tail_tok;
   las_pkg::wave_type  tail_wave;
   logic               fold_hit;
   logic [las_pkg::SCORE_W-1:0] fold_max;

   // ---------------------------------------------------------------- config
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            las_pkg::CSR_MATCH:    cfg_in.match_score      = csr_data;
            las_pkg::CSR_MISMATCH: cfg_in.mismatch_penalty = csr_data;
            las_pkg::CSR_GAP:      cfg_in.gap_penalty      = csr_data;
            default: begin
            end
         endcase
      end
   end

   // ---------------------------------------------------------------- stall
   assign tail_tok    = tok_chain[MAX_QUERY];
   assign tail_wave   = wave_chain[MAX_QUERY];
   assign tail_result = tail_tok.vld && (tail_tok.kind == las_pkg::ACT_REF) && tail_tok.last;
   // hold the whole chain only when a result must land on a full output
   assign advance     = !(tail_result && rsp_valid_ff && !rsp_ready);
   assign req_ready   = advance;
   assign req_fire    = req_valid && req_ready;

   // ---------------------------------------------------------------- head
   always_comb begin
      len_in   = len_ff;
      trunc_in = trunc_ff;
      tok_chain[0].vld   = 1'b0;
      tok_chain[0].kind  = req_data.action;
      tok_chain[0].base  = req_data.base;
      tok_chain[0].last  = req_data.last;
      tok_chain[0].trunc = trunc_ff;
      idx_chain[0]       = len_ff[IDX_W-1:0];
      wave_chain[0]      = '0;
      if (req_fire) begin
         case (req_data.action)
            las_pkg::ACT_APPEND: begin
               if (len_ff == LEN_FULL) begin
                  // drop the base, flag the query
                  trunc_in = 1'b1;
               end else begin
                  tok_chain[0].vld = 1'b1;
                  len_in           = len_ff + LEN_W'(1);
               end
            end
            las_pkg::ACT_REF: begin
               tok_chain[0].vld = 1'b1;
            end
            las_pkg::ACT_CLEAR: begin
               tok_chain[0].vld = 1'b1;
               len_in           = '0;
               trunc_in         = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   // ---------------------------------------------------------------- chain
   for (genvar gi = 0; gi < MAX_QUERY; gi++) begin : g_cell
      las_cell #(
         .IDX_W      (IDX_W),
         .CELL_INDEX (gi)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .cfg     (cfg_ff),
         .tok_i   (tok_chain[gi]),
         .idx_i   (idx_chain[gi]),
         .wave_i  (wave_chain[gi]),
         .tok_o   (tok_chain[gi+1]),
         .idx_o   (idx_chain[gi+1]),
         .wave_o  (wave_chain[gi+1])
      );
   end

   // ---------------------------------------------------------------- tail
   // fold the column maximum into the running best of the window
   always_comb begin
      fold_hit = best_hit_ff || tail_wave.hit;
      fold_max = best_ff;
      if (tail_wave.hit && (!best_hit_ff || (tail_wave.colmax > best_ff))) begin
         fold_max = tail_wave.colmax;
      end
   end

   always_comb begin
      best_hit_in  = best_hit_ff;
      best_in      = best_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (advance && tail_tok.vld) begin
         case (tail_tok.kind)
            las_pkg::ACT_REF: begin
               if (tail_tok.last) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in.score = fold_hit ? $signed({1'b0, fold_max})
                                               : $signed(las_pkg::SCORE_NONE);
                  rsp_data_in.query_truncated = tail_tok.trunc;
                  best_hit_in = 1'b0;
               end else begin
                  best_hit_in = fold_hit;
                  best_in     = fold_max;
               end
            end
            las_pkg::ACT_CLEAR: begin
               best_hit_in = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.match_score      <= las_pkg::MATCH_RESET;
         cfg_ff.mismatch_penalty <= las_pkg::MISMATCH_RESET;
         cfg_ff.gap_penalty      <= las_pkg::GAP_RESET;
         len_ff                  <= '0;
         trunc_ff                <= 1'b0;
         best_hit_ff             <= 1'b0;
         rsp_valid_ff            <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         len_ff       <= len_in;
         trunc_ff     <= trunc_in;
         best_hit_ff  <= best_hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      best_ff     <= best_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   // query length never runs past the chain
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LEN_FULL)
      else $error("query length beyond capacity");

   // truncation only happens on a full query
   a_trunc_full: assert property (@(posedge clock) disable iff (reset)
      trunc_ff |-> (len_ff == LEN_FULL))
      else $error("truncated flag without full query");

   // a blocked result token stays at the tail
   a_tail_hold: assert property (@(posedge clock) disable iff (reset)
      (tail_result && rsp_valid_ff && !rsp_ready) |=> $stable(tok_chain[MAX_QUERY]))
      else $error("result token lost under stall");

   // a result token leaving the tail lands in the output register
   a_tail_load: assert property (@(posedge clock) disable iff (reset)
      (tail_result && advance) |=> rsp_valid_ff)
      else $error("result token dropped at tail");
`endif

endmodule
